FILE: rtl/eabb_pkg.sv
package eabb_pkg;

  localparam int MAX_WIDTH  = 1024;
  localparam int MAX_HEIGHT = 4096;

  localparam int COL_W      = $clog2(MAX_WIDTH);
  localparam int WIDTH_W    = 11;
  localparam int HEIGHT_W   = 13;
  localparam int ROW_W      = HEIGHT_W;
  localparam int CFG_DATA_W = (WIDTH_W > HEIGHT_W) ? WIDTH_W : HEIGHT_W;
  localparam int CFG_IDX_W  = 2;

  localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 2'd1;

  localparam logic [WIDTH_W-1:0]  WIDTH_RESET  = 11'd1024;
  localparam logic [HEIGHT_W-1:0] HEIGHT_RESET = 13'd768;

  localparam int CH_W        = 8;
  localparam int CSUM_W      = 10;
  localparam int TSUM_W      = 12;
  localparam int RECIP_W     = 15;
  localparam int RECIP_SHIFT = 16;
  localparam int PROD_W      = TSUM_W + RECIP_W;

  // Reciprocals scaled by 2**16, rounded up; exact for every sum that can occur.
  localparam logic [RECIP_W-1:0] RECIP_4 = 15'd16384;
  localparam logic [RECIP_W-1:0] RECIP_6 = 15'd10923;
  localparam logic [RECIP_W-1:0] RECIP_9 = 15'd7282;

  localparam logic [TSUM_W-1:0] BIAS_4 = 12'd2;
  localparam logic [TSUM_W-1:0] BIAS_6 = 12'd3;
  localparam logic [TSUM_W-1:0] BIAS_9 = 12'd4;

  typedef struct packed {
    logic [CH_W-1:0] red;
    logic [CH_W-1:0] green;
    logic [CH_W-1:0] blue;
  } pix_t;

  typedef struct packed {
    logic [CSUM_W-1:0] red;
    logic [CSUM_W-1:0] green;
    logic [CSUM_W-1:0] blue;
  } csum_t;

  typedef struct packed {
    logic [TSUM_W-1:0] red;
    logic [TSUM_W-1:0] green;
    logic [TSUM_W-1:0] blue;
  } tsum_t;

  typedef struct packed {
    pix_t upper;
    pix_t middle;
  } line_pair_t;

  typedef struct packed {
    logic [COL_W-1:0] col;
    logic             first_col;
    logic             left_mask;
    logic             top_mask;
    logic             bot_mask;
    logic             produce;
    logic             row_edge;
    logic             col_edge;
    logic             last;
  } item_info_t;

endpackage

FILE: rtl/eabb_ctrl.sv
module eabb_ctrl (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [eabb_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [eabb_pkg::CFG_DATA_W-1:0] cfg_wdata,
  input  logic                           in_fire,
  input  logic                           in_kind,
  output logic                           take,
  output eabb_pkg::item_info_t           info
);
  import eabb_pkg::*;

  logic [WIDTH_W-1:0]  width_r, width_nxt;
  logic [HEIGHT_W-1:0] height_r, height_nxt;
  logic [COL_W-1:0]    col_r, col_nxt;
  logic [ROW_W-1:0]    row_r, row_nxt;

  logic [WIDTH_W-1:0]  width_raw;
  logic [HEIGHT_W-1:0] height_raw;
  logic [ROW_W-1:0]    h_plus1;
  logic [ROW_W-1:0]    row_inc;
  logic [WIDTH_W-1:0]  col_inc;
  logic                row_lt_h;
  logic                col_is0;
  logic                col_is1;
  logic                row_ge2;
  logic                cfg_hit;

  assign width_raw  = cfg_wdata[WIDTH_W-1:0];
  assign height_raw = cfg_wdata[HEIGHT_W-1:0];
  assign cfg_hit    = cfg_we && (cfg_index == REG_FRAME_WIDTH || cfg_index == REG_FRAME_HEIGHT);

  assign h_plus1  = ROW_W'(height_r) + ROW_W'(1);
  assign row_inc  = row_r + ROW_W'(1);
  assign col_inc  = {1'b0, col_r} + WIDTH_W'(1);
  assign row_lt_h = row_r < ROW_W'(height_r);
  assign col_is0  = (col_r == '0);
  assign col_is1  = (col_r == COL_W'(1));
  assign row_ge2  = (row_r >= ROW_W'(2));

  // A drain item is dropped while pixels of the frame are still expected.
  assign take = !(row_lt_h && in_kind);

  // An item at column zero finishes the right edge of the row two above;
  // any other item finishes the pixel up and to the left of it.
  always_comb begin
    info.col       = col_r;
    info.first_col = col_is0;
    info.left_mask = col_is1;
    info.top_mask  = !row_ge2;
    info.bot_mask  = !row_lt_h;
    info.produce   = (row_r != '0) && (!col_is0 || row_ge2);
    info.row_edge  = col_is0 ? (row_r == ROW_W'(2) || row_r == h_plus1)
                             : (row_r == ROW_W'(1) || row_r == ROW_W'(height_r));
    info.col_edge  = col_is0 || col_is1;
    info.last      = col_is0 && (row_r == h_plus1);
  end

  always_comb begin
    width_nxt  = width_r;
    height_nxt = height_r;
    col_nxt    = col_r;
    row_nxt    = row_r;
    if (cfg_hit) begin
      if (cfg_index == REG_FRAME_WIDTH) begin
        if (width_raw < WIDTH_W'(2)) begin
          width_nxt = WIDTH_W'(2);
        end else if (width_raw > WIDTH_W'(MAX_WIDTH)) begin
          width_nxt = WIDTH_W'(MAX_WIDTH);
        end else begin
          width_nxt = width_raw;
        end
      end else begin
        if (height_raw < HEIGHT_W'(2)) begin
          height_nxt = HEIGHT_W'(2);
        end else if (height_raw > HEIGHT_W'(MAX_HEIGHT)) begin
          height_nxt = HEIGHT_W'(MAX_HEIGHT);
        end else begin
          height_nxt = height_raw;
        end
      end
      col_nxt = '0;
      row_nxt = '0;
    end else if (in_fire && take) begin
      if (col_inc >= width_r) begin
        col_nxt = '0;
        row_nxt = row_inc;
      end else begin
        col_nxt = col_inc[COL_W-1:0];
      end
      if (info.last || row_nxt > h_plus1) begin
        col_nxt = '0;
        row_nxt = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= WIDTH_RESET;
      height_r <= HEIGHT_RESET;
      col_r    <= '0;
      row_r    <= '0;
    end else begin
      width_r  <= width_nxt;
      height_r <= height_nxt;
      col_r    <= col_nxt;
      row_r    <= row_nxt;
    end
  end

endmodule

FILE: rtl/eabb_line_mem.sv
module eabb_line_mem (
  input  logic                       clk,
  input  logic                       rd_en,
  input  logic [eabb_pkg::COL_W-1:0] rd_addr,
  output eabb_pkg::line_pair_t       rd_data,
  input  logic                       wr_en,
  input  logic [eabb_pkg::COL_W-1:0] wr_addr,
  input  eabb_pkg::line_pair_t       wr_data
);
  import eabb_pkg::*;

  // Each entry holds the column of the two rows above the current one.
  line_pair_t line_mem [MAX_WIDTH];
  line_pair_t rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      line_mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= line_mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

FILE: rtl/eabb_window.sv
module eabb_window (
  input  logic                 clk,
  input  logic                 shift_en,
  input  eabb_pkg::item_info_t info,
  input  eabb_pkg::line_pair_t pair,
  input  eabb_pkg::pix_t       pix,
  output eabb_pkg::tsum_t      sum,
  output logic                 row_edge,
  output logic                 col_edge,
  output logic                 last
);
  import eabb_pkg::*;

  function automatic csum_t col_add(input pix_t a, input pix_t b, input pix_t c);
    csum_t s;
    s.red   = CSUM_W'(a.red)   + CSUM_W'(b.red)   + CSUM_W'(c.red);
    s.green = CSUM_W'(a.green) + CSUM_W'(b.green) + CSUM_W'(c.green);
    s.blue  = CSUM_W'(a.blue)  + CSUM_W'(b.blue)  + CSUM_W'(c.blue);
    return s;
  endfunction

  function automatic tsum_t win_add(input csum_t a, input csum_t b, input csum_t c);
    tsum_t s;
    s.red   = TSUM_W'(a.red)   + TSUM_W'(b.red)   + TSUM_W'(c.red);
    s.green = TSUM_W'(a.green) + TSUM_W'(b.green) + TSUM_W'(c.green);
    s.blue  = TSUM_W'(a.blue)  + TSUM_W'(b.blue)  + TSUM_W'(c.blue);
    return s;
  endfunction

  // The window keeps only column sums: col_a_r is two columns back,
  // col_b_r one column back.
  csum_t col_a_r;
  csum_t col_b_r;
  csum_t new_col;
  csum_t left_col;
  pix_t  top_pix;
  pix_t  bot_pix;
  tsum_t total;

  tsum_t sum_r;
  logic  row_edge_r;
  logic  col_edge_r;
  logic  last_r;

  always_comb begin
    top_pix  = info.top_mask ? '0 : pair.upper;
    bot_pix  = info.bot_mask ? '0 : pix;
    new_col  = col_add(top_pix, pair.middle, bot_pix);
    left_col = info.left_mask ? '0 : col_a_r;
    // At column zero the finished pixel is the last of the previous row,
    // whose right neighbor lies outside the frame.
    if (info.first_col) begin
      total = win_add(col_a_r, col_b_r, '0);
    end else begin
      total = win_add(left_col, col_b_r, new_col);
    end
  end

  always_ff @(posedge clk) begin
    if (shift_en) begin
      col_a_r    <= col_b_r;
      col_b_r    <= new_col;
      sum_r      <= total;
      row_edge_r <= info.row_edge;
      col_edge_r <= info.col_edge;
      last_r     <= info.last;
    end
  end

  assign sum      = sum_r;
  assign row_edge = row_edge_r;
  assign col_edge = col_edge_r;
  assign last     = last_r;

endmodule

FILE: rtl/eabb_divide.sv
module eabb_divide (
  input  logic            clk,
  input  logic            en,
  input  eabb_pkg::tsum_t sum,
  input  logic            row_edge,
  input  logic            col_edge,
  input  logic            last,
  output eabb_pkg::pix_t  mean,
  output logic            mean_last
);
  import eabb_pkg::*;

  function automatic logic [CH_W-1:0] scaled_div(input logic [TSUM_W-1:0] s,
                                                 input logic [TSUM_W-1:0] bias,
                                                 input logic [RECIP_W-1:0] recip);
    logic [PROD_W-1:0] prod;
    prod = PROD_W'(s + bias) * PROD_W'(recip);
    return prod[RECIP_SHIFT +: CH_W];
  endfunction

  logic [TSUM_W-1:0]  bias;
  logic [RECIP_W-1:0] recip;
  pix_t               mean_r;
  logic               mean_last_r;

  // Corners average four pixels, other border pixels six, the rest nine.
  always_comb begin
    case ({row_edge, col_edge})
      2'b11: begin
        bias  = BIAS_4;
        recip = RECIP_4;
      end
      2'b10, 2'b01: begin
        bias  = BIAS_6;
        recip = RECIP_6;
      end
      default: begin
        bias  = BIAS_9;
        recip = RECIP_9;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (en) begin
      mean_r.red   <= scaled_div(sum.red, bias, recip);
      mean_r.green <= scaled_div(sum.green, bias, recip);
      mean_r.blue  <= scaled_div(sum.blue, bias, recip);
      mean_last_r  <= last;
    end
  end

  assign mean      = mean_r;
  assign mean_last = mean_last_r;

endmodule

FILE: rtl/edge_aware_box_blur_3x3_top.sv
// Channel  Dir  Handshake            Payload
// in       in   in_valid/in_ready    in_kind, in_red_in, in_green_in, in_blue_in
// out      out  out_valid/out_ready  out_red_out, out_green_out, out_blue_out,
//                                    out_last_of_frame
// cfg      in   cfg_we               cfg_index, cfg_wdata
//
// One item per cycle while not stalled; the item that completes a neighborhood comes
// one row plus one pixel later, and its result passes the window and divide registers.
// The rate is set by the line memory, which does one read and one write per item.
// Reset clears the counters and stage valids and restores a 1024 x 768 frame; the
// line memory is not cleared and needs no clearing pass.
// Each stage holds its item only while the next one is full, so input transfers
// continue into empty stages while a result waits on out_ready.
module edge_aware_box_blur_3x3_top (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic                           in_kind,
  input  logic [7:0]                     in_red_in,
  input  logic [7:0]                     in_green_in,
  input  logic [7:0]                     in_blue_in,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [7:0]                     out_red_out,
  output logic [7:0]                     out_green_out,
  output logic [7:0]                     out_blue_out,
  output logic                           out_last_of_frame,
  input  logic                           cfg_we,
  input  logic [eabb_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [eabb_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import eabb_pkg::*;

  logic       out_free;
  logic       s2_free;
  logic       s1_free;
  logic       in_fire;
  logic       take;
  item_info_t s0_info;

  logic       s1_v_r;
  item_info_t s1_info_r;
  pix_t       s1_pix_r;
  logic       s2_v_r;
  logic       out_valid_r;

  logic       rd_en;
  logic       wr_en;
  line_pair_t rd_data;
  line_pair_t wr_data;
  logic       shift_en;

  tsum_t      s2_sum;
  logic       s2_row_edge;
  logic       s2_col_edge;
  logic       s2_last;
  logic       div_en;
  pix_t       mean;
  logic       mean_last;

  assign out_free = !out_valid_r || out_ready;
  assign s2_free  = !s2_v_r || out_free;
  assign s1_free  = !s1_v_r || s2_free;
  assign in_ready = s1_free;
  assign in_fire  = in_valid && s1_free;

  eabb_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_fire   (in_fire),
    .in_kind   (in_kind),
    .take      (take),
    .info      (s0_info)
  );

  // The read for an item is issued on its transfer; the write back happens
  // when it leaves the first stage, so the shift of the line pair is one
  // read-modify-write per column.
  assign rd_en          = in_fire && take;
  assign wr_en          = s1_v_r && s2_free;
  assign wr_data.upper  = rd_data.middle;
  assign wr_data.middle = s1_pix_r;

  eabb_line_mem u_line_mem (
    .clk     (clk),
    .rd_en   (rd_en),
    .rd_addr (s0_info.col),
    .rd_data (rd_data),
    .wr_en   (wr_en),
    .wr_addr (s1_info_r.col),
    .wr_data (wr_data)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (s1_free) begin
      s1_v_r <= in_fire && take;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_free) begin
      s1_info_r    <= s0_info;
      s1_pix_r.red   <= in_red_in;
      s1_pix_r.green <= in_green_in;
      s1_pix_r.blue  <= in_blue_in;
    end
  end

  assign shift_en = s1_v_r && s2_free;

  eabb_window u_window (
    .clk      (clk),
    .shift_en (shift_en),
    .info     (s1_info_r),
    .pair     (rd_data),
    .pix      (s1_pix_r),
    .sum      (s2_sum),
    .row_edge (s2_row_edge),
    .col_edge (s2_col_edge),
    .last     (s2_last)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_v_r <= 1'b0;
    end else if (s2_free) begin
      s2_v_r <= s1_v_r && s1_info_r.produce;
    end
  end

  assign div_en = s2_v_r && out_free;

  eabb_divide u_divide (
    .clk       (clk),
    .en        (div_en),
    .sum       (s2_sum),
    .row_edge  (s2_row_edge),
    .col_edge  (s2_col_edge),
    .last      (s2_last),
    .mean      (mean),
    .mean_last (mean_last)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= s2_v_r;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_red_out       = mean.red;
  assign out_green_out     = mean.green;
  assign out_blue_out      = mean.blue;
  assign out_last_of_frame = mean_last;

  // The first item of a new frame may read the column that the final flush item
  // writes back; that read lies above the frame and is never used.
  a_mem_no_collision: assert property (@(posedge clk) disable iff (!rst_n)
    (rd_en && wr_en && !s1_info_r.last) |-> (s0_info.col != s1_info_r.col))
    else $error("line memory read and write hit the same column");

  a_result_delivered: assert property (@(posedge clk) disable iff (!rst_n)
    (s2_v_r && out_free) |=> out_valid_r)
    else $error("finished sum did not reach the output register");

  a_frame_restart: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && take && s0_info.last && !cfg_we) |=>
      (s0_info.first_col && s0_info.top_mask && !s0_info.produce))
    else $error("counters did not return to frame start after the last pixel");

endmodule

FILE: test/edge_aware_box_blur_3x3_top_tb.sv
`timescale 1ns / 100ps

module edge_aware_box_blur_3x3_top_tb;
  import eabb_pkg::*;

  localparam logic KIND_PIXEL = 1'b0;
  localparam logic KIND_DRAIN = 1'b1;

  // Register indexes that decode to nothing.
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_2 = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_3 = 2'd3;

  localparam int SETTLE_CYCLES  = 12;
  localparam int HOLD_CYCLES    = 300;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int RANDOM_ITEMS   = 600;
  localparam int SHORT_RUN      = 30;

  typedef struct packed {
    pix_t color;
    logic last;
  } blurred_pixel_t;

  logic                  clk;
  logic                  rst_n      = 1'b0;
  logic                  in_valid   = 1'b0;
  logic                  in_ready;
  logic                  in_kind    = KIND_PIXEL;
  logic [7:0]            in_red_in  = '0;
  logic [7:0]            in_green_in = '0;
  logic [7:0]            in_blue_in = '0;
  logic                  out_valid;
  logic                  out_ready  = 1'b0;
  logic [7:0]            out_red_out;
  logic [7:0]            out_green_out;
  logic [7:0]            out_blue_out;
  logic                  out_last_of_frame;
  logic                  cfg_we     = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index  = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata  = '0;

  // Blur predictor state: four rows of pixels indexed by row modulo 4.
  pix_t line_ring [4][MAX_WIDTH];
  int   width_cfg  = int'(WIDTH_RESET);
  int   height_cfg = int'(HEIGHT_RESET);
  int   row_pos    = 0;
  int   col_pos    = 0;

  blurred_pixel_t expected_pixels[$];
  int             mismatch_count = 0;
  int             items_sent     = 0;
  int             stall_cycles   = 0;
  logic           steady         = 1'b0;
  logic           hold_req       = 1'b0;

  edge_aware_box_blur_3x3_top dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_kind           (in_kind),
    .in_red_in         (in_red_in),
    .in_green_in       (in_green_in),
    .in_blue_in        (in_blue_in),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_red_out       (out_red_out),
    .out_green_out     (out_green_out),
    .out_blue_out      (out_blue_out),
    .out_last_of_frame (out_last_of_frame),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_wdata         (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (steady || roll < 50) return 0;
    if (roll < 85) return $urandom_range(1, 3);
    if (roll < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [7:0] rand_channel();
    int roll;
    roll = $urandom_range(0, 7);
    if (roll == 0) return 8'h00;
    if (roll == 1) return 8'hFF;
    return 8'($urandom_range(0, 255));
  endfunction

  function automatic pix_t rand_pixel();
    return {rand_channel(), rand_channel(), rand_channel()};
  endfunction

  function automatic int clamp_geometry(int v, int lo, int hi);
    if (v < lo) return lo;
    if (v > hi) return hi;
    return v;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("%0t: mismatch: %s", $realtime, msg);
    mismatch_count++;
  endtask

  // Advances the blur predictor by one accepted item and queues the pixel it completes.
  task automatic predict_blur(input logic kind, input pix_t px);
    int             orow, ocol, rr, cc, taps;
    int             sum_r, sum_g, sum_b;
    logic           frame_done;
    blurred_pixel_t res;
    frame_done = 1'b0;
    if (row_pos < height_cfg) begin
      if (kind == KIND_DRAIN) return;
      line_ring[row_pos % 4][col_pos] = px;
    end
    if (row_pos >= 1 && (col_pos >= 1 || row_pos >= 2)) begin
      if (col_pos == 0) begin
        orow = row_pos - 2;
        ocol = width_cfg - 1;
      end else begin
        orow = row_pos - 1;
        ocol = col_pos - 1;
      end
      sum_r = 0;
      sum_g = 0;
      sum_b = 0;
      taps  = 0;
      for (rr = orow - 1; rr <= orow + 1; rr++) begin
        for (cc = ocol - 1; cc <= ocol + 1; cc++) begin
          if (rr >= 0 && rr < height_cfg && cc >= 0 && cc < width_cfg) begin
            sum_r += line_ring[rr % 4][cc].red;
            sum_g += line_ring[rr % 4][cc].green;
            sum_b += line_ring[rr % 4][cc].blue;
            taps++;
          end
        end
      end
      res.color.red   = 8'((sum_r + taps / 2) / taps);
      res.color.green = 8'((sum_g + taps / 2) / taps);
      res.color.blue  = 8'((sum_b + taps / 2) / taps);
      frame_done = (orow == height_cfg - 1) && (ocol == width_cfg - 1);
      res.last = frame_done;
      expected_pixels.push_back(res);
    end
    col_pos++;
    if (col_pos >= width_cfg) begin
      col_pos = 0;
      row_pos++;
    end
    if (frame_done || row_pos > height_cfg + 1) begin
      row_pos = 0;
      col_pos = 0;
    end
  endtask

  // Starts and ends at a rising edge; valid stays high when the next item follows at once.
  task automatic send_item(input logic kind, input pix_t px);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid    <= 1'b1;
    in_kind     <= kind;
    in_red_in   <= px.red;
    in_green_in <= px.green;
    in_blue_in  <= px.blue;
    do @(posedge clk); while (!in_ready);
    predict_blur(kind, px);
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (expected_pixels.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                input logic [CFG_DATA_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == REG_FRAME_WIDTH) begin
      width_cfg = clamp_geometry(int'(data[WIDTH_W-1:0]), 2, MAX_WIDTH);
      row_pos = 0;
      col_pos = 0;
    end else if (idx == REG_FRAME_HEIGHT) begin
      height_cfg = clamp_geometry(int'(data[HEIGHT_W-1:0]), 2, MAX_HEIGHT);
      row_pos = 0;
      col_pos = 0;
    end
    @(posedge clk);
  endtask

  // Sends one frame at the current geometry followed by its flush items. Stray drains
  // among the pixels are ignored; stray pixels among the flush items act as drains.
  // stop_at cuts the frame short; pause_at idles the block there and writes a spare index.
  task automatic send_frame(input int noise_pct, input int stray_pct,
                            input int stop_at, input int pause_at);
    int total;
    total = width_cfg * height_cfg;
    for (int p = 0; p < total; p++) begin
      if (p == stop_at) return;
      if (p == pause_at) begin
        wait_idle();
        write_register($urandom_range(0, 1) ? REG_SPARE_2 : REG_SPARE_3,
                       CFG_DATA_W'($urandom()));
      end
      if ($urandom_range(0, 99) < noise_pct) send_item(KIND_DRAIN, rand_pixel());
      send_item(KIND_PIXEL, rand_pixel());
      items_sent++;
    end
    for (int p = 0; p <= width_cfg; p++) begin
      send_item(($urandom_range(0, 99) < stray_pct) ? KIND_PIXEL : KIND_DRAIN, rand_pixel());
      items_sent++;
    end
  endtask

  task automatic test_reset_geometry();
    // At the 1024-pixel reset width none of these items completes a neighborhood.
    for (int i = 0; i < 40; i++) send_item(KIND_PIXEL, rand_pixel());
    wait_idle();
  endtask

  task automatic test_smallest_frame();
    write_register(REG_FRAME_WIDTH, CFG_DATA_W'(2));
    write_register(REG_FRAME_HEIGHT, CFG_DATA_W'(2));
    send_item(KIND_PIXEL, 24'hFFFFFF);
    send_item(KIND_PIXEL, 24'h000000);
    send_item(KIND_PIXEL, 24'hFF00FF);
    send_item(KIND_PIXEL, 24'h00FF01);
    repeat (3) send_item(KIND_DRAIN, rand_pixel());
    // Drains inside the frame are dropped; pixels after the last one flush.
    send_item(KIND_DRAIN, rand_pixel());
    send_item(KIND_PIXEL, 24'h00FF00);
    send_item(KIND_PIXEL, 24'hFF00FF);
    send_item(KIND_DRAIN, rand_pixel());
    send_item(KIND_PIXEL, 24'hFFFF00);
    send_item(KIND_PIXEL, 24'h0000FF);
    send_item(KIND_PIXEL, rand_pixel());
    send_item(KIND_DRAIN, rand_pixel());
    send_item(KIND_PIXEL, rand_pixel());
    wait_idle();
  endtask

  task automatic test_saturated_frame();
    write_register(REG_FRAME_WIDTH, CFG_DATA_W'(3));
    write_register(REG_FRAME_HEIGHT, CFG_DATA_W'(3));
    repeat (9) send_item(KIND_PIXEL, 24'hFFFFFF);
    repeat (4) send_item(KIND_DRAIN, 24'hFFFFFF);
    wait_idle();
  endtask

  task automatic test_register_clamp();
    write_register(REG_FRAME_WIDTH, CFG_DATA_W'(0));
    write_register(REG_FRAME_HEIGHT, CFG_DATA_W'(1));
    send_frame(0, 0, -1, -1);
    wait_idle();
    // Bits above the width field are dropped before the clamp.
    write_register(REG_FRAME_WIDTH, 13'h1801);
    write_register(REG_FRAME_HEIGHT, CFG_DATA_W'(0));
    send_frame(0, 0, -1, -1);
    wait_idle();
  endtask

  task automatic test_spare_index();
    write_register(REG_FRAME_WIDTH, CFG_DATA_W'(4));
    write_register(REG_FRAME_HEIGHT, CFG_DATA_W'(3));
    send_frame(0, 0, -1, 6);
    wait_idle();
  endtask

  task automatic test_restart_on_write();
    send_frame(0, 0, 7, -1);
    wait_idle();
    write_register(REG_FRAME_HEIGHT, CFG_DATA_W'(3));
    send_frame(0, 0, -1, -1);
    wait_idle();
  endtask

  // The clamped frames are far too long to finish, so only their start is sent.
  task automatic test_widest_frame();
    write_register(REG_FRAME_WIDTH, 13'h1FFF);
    write_register(REG_FRAME_HEIGHT, CFG_DATA_W'(2));
    send_frame(0, 0, SHORT_RUN, -1);
    wait_idle();
  endtask

  task automatic test_tallest_frame();
    write_register(REG_FRAME_WIDTH, CFG_DATA_W'(2));
    write_register(REG_FRAME_HEIGHT, 13'h1FFF);
    send_frame(0, 0, SHORT_RUN, -1);
    wait_idle();
  endtask

  task automatic test_result_backpressure();
    write_register(REG_FRAME_WIDTH, CFG_DATA_W'(20));
    write_register(REG_FRAME_HEIGHT, CFG_DATA_W'(5));
    steady   = 1'b1;
    hold_req = 1'b1;
    send_frame(0, 0, -1, -1);
    steady = 1'b0;
    wait_idle();
  endtask

  task automatic test_random_frames();
    int                    frame_kind;
    int                    first_item;
    logic [CFG_DATA_W-1:0] geo;
    first_item = items_sent;
    while (items_sent - first_item < RANDOM_ITEMS) begin
      frame_kind = $urandom_range(0, 99);
      if ($urandom_range(0, 2) == 0) begin
        wait_idle();
        geo = CFG_DATA_W'($urandom_range(2, ($urandom_range(0, 9) == 0) ? 40 : 10));
        if ($urandom_range(0, 7) == 0) geo = CFG_DATA_W'($urandom_range(0, 1));
        geo[CFG_DATA_W-1:WIDTH_W] = 2'($urandom_range(0, 3));
        write_register(REG_FRAME_WIDTH, geo);
      end
      if ($urandom_range(0, 2) == 0) begin
        wait_idle();
        geo = ($urandom_range(0, 7) == 0) ? CFG_DATA_W'($urandom_range(0, 1))
                                          : CFG_DATA_W'($urandom_range(2, 8));
        write_register(REG_FRAME_HEIGHT, geo);
      end
      steady = ($urandom_range(0, 9) == 0);
      if (frame_kind < 8) begin
        // Abandon the frame part way; rewriting the width restarts it.
        send_frame(10, 30, $urandom_range(1, width_cfg * height_cfg - 1), -1);
        wait_idle();
        write_register(REG_FRAME_WIDTH, CFG_DATA_W'(width_cfg));
      end else if (frame_kind < 14) begin
        send_frame(10, 30, -1, $urandom_range(1, width_cfg * height_cfg - 1));
      end else begin
        send_frame(10, 30, -1, -1);
      end
      if ($urandom_range(0, 19) == 0) send_item(KIND_DRAIN, rand_pixel());
    end
    steady = 1'b0;
    wait_idle();
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_geometry();
    test_smallest_frame();
    test_saturated_frame();
    test_register_clamp();
    test_spare_index();
    test_restart_on_write();
    test_result_backpressure();
    test_random_frames();
    test_widest_frame();
    test_tallest_frame();
    wait_idle();
    if (mismatch_count == 0) begin
      $display("edge_aware_box_blur_3x3_top_tb OK");
    end else begin
      $display("edge_aware_box_blur_3x3_top_tb NOT OK");
    end
    $finish;
  end

  // Result side: random stalls, plus one long hold-off on request.
  initial begin : drive_out_ready
    int gap;
    @(posedge clk);
    forever begin
      if (hold_req) begin
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
      end
      gap = pick_gap();
      if (gap > 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ready <= 1'b1;
      repeat ($urandom_range(1, 16)) @(posedge clk);
    end
  end

  always @(posedge clk) begin : check_results
    blurred_pixel_t want;
    if (rst_n && out_valid && out_ready) begin
      if (expected_pixels.size() == 0) begin
        report_mismatch($sformatf("unexpected result %0d %0d %0d last %0d",
                                  out_red_out, out_green_out, out_blue_out,
                                  out_last_of_frame));
      end else begin
        want = expected_pixels.pop_front();
        if (out_red_out !== want.color.red)
          report_mismatch($sformatf("red %0d, want %0d", out_red_out, want.color.red));
        if (out_green_out !== want.color.green)
          report_mismatch($sformatf("green %0d, want %0d", out_green_out, want.color.green));
        if (out_blue_out !== want.color.blue)
          report_mismatch($sformatf("blue %0d, want %0d", out_blue_out, want.color.blue));
        if (out_last_of_frame !== want.last)
          report_mismatch($sformatf("last_of_frame %0d, want %0d", out_last_of_frame,
                                    want.last));
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= WATCHDOG_LIMIT) begin
        $display("edge_aware_box_blur_3x3_top_tb NOT OK");
        $finish;
      end
    end
  end

endmodule

FILE: edge_aware_box_blur_3x3_top.f
rtl/eabb_pkg.sv
rtl/eabb_ctrl.sv
rtl/eabb_line_mem.sv
rtl/eabb_window.sv
rtl/eabb_divide.sv
rtl/edge_aware_box_blur_3x3_top.sv
test/edge_aware_box_blur_3x3_top_tb.sv
